[rtl/core/mnmf_pkg.sv]
// mnmf_pkg: shared constants, types and the distance test of the noise mask filter
// no dependencies; imported by mnmf_cell, mnmf_chain and marker_noise_mask_filter
package mnmf_pkg;

  // table sizes
  localparam int CAMERAS     = 8;
  localparam int NOISE_DEPTH = 64;

  localparam int CAM_W = (CAMERAS > 1) ? $clog2(CAMERAS) : 1;
  localparam int IDX_W = (NOISE_DEPTH > 1) ? $clog2(NOISE_DEPTH) : 1;
  localparam int CNT_W = $clog2(NOISE_DEPTH + 1);

  // field widths
  localparam int CAMID_W = 3;
  localparam int COORD_W = 16;
  localparam int AREA_W  = 16;
  localparam int MODE_W  = 2;

  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 40;

  // operating modes
  localparam logic [MODE_W-1:0] MODE_FILTER = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LEARN  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_STOP   = 2'd2;

  // configuration register indexes
  localparam logic REG_MODE           = 1'b0;
  localparam logic REG_AREA_THRESHOLD = 1'b1;

  // one pixel squared in 12.4 units
  localparam logic [8:0] ONE_PIXEL_SQ = 9'd256;

  // search token handed from cell to cell
  typedef struct packed {
    logic               valid;
    logic [CAM_W-1:0]   cam;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [CNT_W-1:0]   rem;
    logic               hit;
  } tok_t;

  // table write broadcast to the row
  typedef struct packed {
    logic               en;
    logic [CAM_W-1:0]   cam;
    logic [IDX_W-1:0]   idx;
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
  } wr_t;

  // true when the squared distance is below one pixel squared
  function automatic logic near_point(input logic [COORD_W-1:0] px,
                                      input logic [COORD_W-1:0] py,
                                      input logic [COORD_W-1:0] x,
                                      input logic [COORD_W-1:0] y);
    logic [COORD_W-1:0] dx;
    logic [COORD_W-1:0] dy;
    logic [8:0]         sum;
    dx  = (px > x) ? (px - x) : (x - px);
    dy  = (py > y) ? (py - y) : (y - py);
    // only offsets below 16 can give a sum below 256
    sum = 9'(dx[3:0] * dx[3:0]) + 9'(dy[3:0] * dy[3:0]);
    return (dx[COORD_W-1:4] == '0) && (dy[COORD_W-1:4] == '0) && (sum < ONE_PIXEL_SQ);
  endfunction

endpackage

[rtl/core/marker_noise_mask_filter.sv]
// marker_noise_mask_filter: top level with stream ports, settings, counts and result stage
// depends on mnmf_pkg and mnmf_chain
//
// One blob item at a time: on acceptance a search token enters a row of NOISE_DEPTH cells,
// each holding one table slot for every camera, and visits one cell per cycle; the blob's
// result passes from the last cell through a result register into the output register,
// and the next blob is accepted only after that. While the output register
// is held, a finished result waits in front of it and the input stays closed. A learned
// point is written into its cell as the token leaves the row. The noise table has no reset
// and is only read below each camera's count, which reset clears. The user must see that
// settings are written only while idle; the block itself does not enforce it.
module marker_noise_mask_filter
  import mnmf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [AREA_W-1:0]     cfg_data,
  // blob items in
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // camera_id, marker_x, marker_y, blob_area
  // results out
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata    // out_camera, out_x, out_y, kept, learned, table_full
);

  logic [MODE_W-1:0]  mode;
  logic [AREA_W-1:0]  area_threshold;
  logic [CNT_W-1:0]   noise_count [CAMERAS];

  logic               busy;
  logic               in_accept;
  logic [CAMID_W-1:0] in_cam;
  logic [COORD_W-1:0] in_x;
  logic [COORD_W-1:0] in_y;
  logic [AREA_W-1:0]  in_area;
  logic [CAM_W-1:0]   in_cam_idx;
  logic               in_use;

  logic [CAMID_W-1:0] item_cam;
  logic [COORD_W-1:0] item_x;
  logic [COORD_W-1:0] item_y;
  logic [MODE_W-1:0]  item_mode;
  logic               item_use;
  logic [CNT_W-1:0]   item_count;

  tok_t               launch;
  tok_t               done;
  wr_t                wr;

  logic               has_room;
  logic               kept_next;
  logic               learn_try;
  logic               fin_valid;
  logic [OUT_DATA_W-1:0] fin_data;
  logic               move_out;

  // input field split
  assign in_cam     = s_tdata[2:0];
  assign in_x       = s_tdata[18:3];
  assign in_y       = s_tdata[34:19];
  assign in_area    = s_tdata[50:35];
  assign in_cam_idx = CAM_W'(in_cam);

  assign s_tready  = !busy;
  assign in_accept = s_tvalid && s_tready;

  // blob is looked at only for a present camera, a large area and an active mode
  assign in_use = (32'(in_cam) < CAMERAS) && (in_area > area_threshold) &&
                  ((mode == MODE_FILTER) || (mode == MODE_LEARN));

  // settings registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_FILTER;
      area_threshold <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE:           mode           <= cfg_data[MODE_W-1:0];
        REG_AREA_THRESHOLD: area_threshold <= cfg_data;
        default:            ;
      endcase
    end
  end

  // token launched into the row
  always_comb begin
    launch.valid = in_accept;
    launch.cam   = in_cam_idx;
    launch.x     = in_x;
    launch.y     = in_y;
    launch.rem   = in_use ? noise_count[in_cam_idx] : '0;
    launch.hit   = 1'b0;
  end

  // item held for the echo fields and the final decision
  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_cam   <= in_cam;
      item_x     <= in_x;
      item_y     <= in_y;
      item_mode  <= mode;
      item_use   <= in_use;
      item_count <= noise_count[in_cam_idx];
    end
  end

  mnmf_chain u_chain (
    .clk     (clk),
    .rst     (rst),
    .wr      (wr),
    .tok_in  (launch),
    .tok_out (done)
  );

  // decision as the token leaves the row
  assign has_room  = item_count < CNT_W'(NOISE_DEPTH);
  assign kept_next = item_use && (item_mode == MODE_FILTER) && !done.hit;
  assign learn_try = item_use && (item_mode == MODE_LEARN) && !done.hit;

  always_comb begin
    wr.en  = done.valid && learn_try && has_room;
    wr.cam = done.cam;
    wr.idx = item_count[IDX_W-1:0];
    wr.px  = item_x;
    wr.py  = item_y;
  end

  // per camera fill counts
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CAMERAS; c++) begin
        noise_count[c] <= '0;
      end
    end else if (wr.en) begin
      noise_count[wr.cam] <= item_count + CNT_W'(1);
    end
  end

  // finished result waiting for the output register
  assign move_out = fin_valid && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (done.valid) begin
      fin_valid <= 1'b1;
    end else if (move_out) begin
      fin_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done.valid) begin
      fin_data <= {2'b00,
                   learn_try && !has_room,
                   learn_try && has_room,
                   kept_next,
                   item_y, item_x, item_cam};
    end
  end

  // busy from acceptance until the result enters the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (in_accept) begin
      busy <= 1'b1;
    end else if (move_out) begin
      busy <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (move_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move_out) begin
      m_tdata <= fin_data;
    end
  end

endmodule

[rtl/core/mnmf_cell.sv]
// mnmf_cell: one slot of the noise table for every camera, with its distance compare
// depends on mnmf_pkg
module mnmf_cell
  import mnmf_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [IDX_W-1:0] cell_idx,
  input  wr_t              wr,
  input  tok_t             tok_in,
  output tok_t             tok_out
);

  logic [2*COORD_W-1:0] entries [CAMERAS];
  logic [2*COORD_W-1:0] pt;
  tok_t                 tok;

  // slot store: written by the broadcast, read at the token's camera
  always_ff @(posedge clk) begin
    if (wr.en && (wr.idx == cell_idx)) begin
      entries[wr.cam] <= {wr.py, wr.px};
    end
    pt <= entries[tok_in.cam];
  end

  // token register
  always_ff @(posedge clk) begin
    if (rst) begin
      tok.valid <= 1'b0;
    end else begin
      tok.valid <= tok_in.valid;
    end
    tok.cam <= tok_in.cam;
    tok.x   <= tok_in.x;
    tok.y   <= tok_in.y;
    tok.rem <= tok_in.rem;
    tok.hit <= tok_in.hit;
  end

  // compare against the slot while it lies below the camera's count
  always_comb begin
    tok_out = tok;
    if (tok.rem != '0) begin
      tok_out.rem = tok.rem - CNT_W'(1);
      tok_out.hit = tok.hit | near_point(pt[COORD_W-1:0], pt[2*COORD_W-1:COORD_W],
                                         tok.x, tok.y);
    end
  end

endmodule

[rtl/core/mnmf_chain.sv]
// mnmf_chain: row of NOISE_DEPTH cells, the token steps one cell per cycle
// depends on mnmf_pkg and mnmf_cell
module mnmf_chain
  import mnmf_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  wr_t  wr,
  input  tok_t tok_in,
  output tok_t tok_out
);

  tok_t link [NOISE_DEPTH+1];

  assign link[0] = tok_in;

  // the row of cells
  for (genvar i = 0; i < NOISE_DEPTH; i++) begin : g_cell
    mnmf_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .cell_idx (IDX_W'(i)),
      .wr       (wr),
      .tok_in   (link[i]),
      .tok_out  (link[i+1])
    );
  end

  assign tok_out = link[NOISE_DEPTH];

endmodule
